@@ rtl/core/pli_pkg.sv @@
`default_nettype none

package pli_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int DATA_W    = 32;
    localparam int QUO_W     = 48;
    localparam int PROD_W    = 50;
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = 6;
    localparam int MUL_STEPS = 32;
    localparam int MUL_CNT_W = 5;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_H,
        ADDR_H_NEXT
    } addr_sel_t;

    typedef struct packed {
        logic      wr_node;
        logic      load_query;
        addr_sel_t rd_sel;
        logic      cap_x0;
        logic      clamp;
        logic      h_dec;
        logic      h_inc;
        logic      set_hint;
        logic      cap_lo;
        logic      cap_hi;
        logic      div_start;
        logic      mul_start;
        logic      load_out;
    } pli_cmd_t;

    typedef struct packed {
        logic x_le_q;
        logic h_lt_lm1;
        logic h1_lt_lm1;
        logic h_zero;
        logic dx_pos;
        logic div_done;
        logic mul_done;
    } pli_status_t;

endpackage

`default_nettype wire

@@ rtl/core/pli_div.sv @@
`default_nettype none

module pli_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pli_pkg::QUO_W-1:0]       dividend,
    input  logic [pli_pkg::DATA_W-1:0]      divisor,
    output logic [pli_pkg::QUO_W-1:0]       quotient,
    output logic                            done
);
    import pli_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DATA_W-1:0]    dsr_reg;

    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      rem_sub;
    logic                 take;
    logic [DATA_W-1:0]    rem_next;

    // One restoring division step per cycle, most significant bit first.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[QUO_W-1]};
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        take     = (rem_sh >= {1'b0, dsr_reg});
        rem_next = take ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/pli_mul.sv @@
`default_nettype none

module pli_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [pli_pkg::PROD_W-1:0] multiplicand,
    input  logic [pli_pkg::DATA_W-1:0]        multiplier,
    output logic signed [pli_pkg::PROD_W-1:0] product,
    output logic                              done
);
    import pli_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    a_reg;
    logic [DATA_W-1:0]    b_reg;

    // The product is known to fit, so the sum is kept modulo its width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= multiplicand;
            b_reg   <= multiplier;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[PROD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[DATA_W-1:1]};
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/pli_datapath.sv @@
`default_nettype none

module pli_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pli_pkg::pli_cmd_t                 cmd,
    output pli_pkg::pli_status_t              status,
    input  logic                              node_count_we,
    input  logic [pli_pkg::COUNT_W-1:0]       node_count,
    input  logic [pli_pkg::IDX_W-1:0]         node_index,
    input  logic signed [pli_pkg::DATA_W-1:0] node_x,
    input  logic signed [pli_pkg::DATA_W-1:0] node_y,
    input  logic signed [pli_pkg::DATA_W-1:0] query_x,
    output logic signed [pli_pkg::DATA_W-1:0] value,
    output logic [pli_pkg::IDX_W-1:0]         segment,
    output logic                              out_of_range
);
    import pli_pkg::*;

    logic signed [DATA_W-1:0] x_mem [MAX_NODES];
    logic signed [DATA_W-1:0] y_mem [MAX_NODES];

    logic [COUNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]         hint_reg;
    logic [IDX_W-1:0]         h_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic                     flag_reg;
    logic signed [DATA_W-1:0] x0_reg;
    logic signed [DATA_W-1:0] xi_reg;
    logic signed [DATA_W-1:0] yi_reg;
    logic signed [DATA_W:0]   dx_reg;
    logic signed [DATA_W:0]   dy_reg;
    logic [DATA_W-1:0]        off_reg;
    logic signed [DATA_W-1:0] rd_x_reg;
    logic signed [DATA_W-1:0] rd_y_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]         segment_reg;
    logic                     oor_reg;

    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         lm1;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W:0]   off_full;
    logic [DATA_W-1:0]        off_next;
    logic signed [DATA_W:0]   dy_abs;
    logic [QUO_W-1:0]         dividend;
    logic [QUO_W-1:0]         quotient;
    logic [PROD_W-1:0]        grad_mag;
    logic signed [PROD_W-1:0] grad;
    logic signed [PROD_W-1:0] product;
    logic signed [DATA_W+2:0] sum;
    logic signed [DATA_W-1:0] sat_value;
    logic signed [DATA_W-1:0] value_next;
    logic                     div_done;
    logic                     mul_done;

    always_comb
    begin
        if (count_reg < COUNT_W'(2))
        begin
            last_idx = IDX_W'(1);
        end
        else if (count_reg > COUNT_W'(MAX_NODES))
        begin
            last_idx = IDX_W'(MAX_NODES - 1);
        end
        else
        begin
            last_idx = IDX_W'(count_reg - 1'b1);
        end
        lm1 = last_idx - 1'b1;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            ADDR_ZERO:   rd_addr = '0;
            ADDR_LAST:   rd_addr = last_idx;
            ADDR_H:      rd_addr = h_reg;
            ADDR_H_NEXT: rd_addr = h_reg + 1'b1;
            default:     rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_node)
        begin
            x_mem[node_index] <= node_x;
            y_mem[node_index] <= node_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    always_comb
    begin
        off_full = {q_reg[DATA_W-1], q_reg} - {xi_reg[DATA_W-1], xi_reg};
        if (off_full[DATA_W])
        begin
            off_next = '0;
        end
        else if (off_full > dx_reg)
        begin
            off_next = dx_reg[DATA_W-1:0];
        end
        else
        begin
            off_next = off_full[DATA_W-1:0];
        end
        dy_abs   = dy_reg[DATA_W] ? -dy_reg : dy_reg;
        dividend = {dy_abs[DATA_W-1:0], 16'h0000};
        grad_mag = {2'b00, quotient};
        grad     = dy_reg[DATA_W] ? -grad_mag : grad_mag;
    end

    // The arithmetic shift by sixteen rounds the scaled product toward minus infinity.
    always_comb
    begin
        sum = {{3{yi_reg[DATA_W-1]}}, yi_reg} + {product[PROD_W-1], product[PROD_W-1:16]};
        if (!sum[DATA_W+2] && (sum[DATA_W+1:DATA_W-1] != 3'b000))
        begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (sum[DATA_W+2] && (sum[DATA_W+1:DATA_W-1] != 3'b111))
        begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = sum[DATA_W-1:0];
        end
        value_next = status.dx_pos ? sat_value : yi_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(2);
            hint_reg  <= '0;
            h_reg     <= '0;
        end
        else
        begin
            if (node_count_we)
            begin
                count_reg <= node_count;
            end
            if (cmd.load_query)
            begin
                h_reg <= (hint_reg > lm1) ? lm1 : hint_reg;
            end
            else if (cmd.h_inc)
            begin
                h_reg <= h_reg + 1'b1;
            end
            else if (cmd.h_dec)
            begin
                h_reg <= h_reg - 1'b1;
            end
            if (cmd.set_hint)
            begin
                hint_reg <= h_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_reg <= query_x;
        end
        if (cmd.cap_x0)
        begin
            x0_reg <= rd_x_reg;
        end
        if (cmd.clamp)
        begin
            if (q_reg < x0_reg)
            begin
                q_reg    <= x0_reg;
                flag_reg <= 1'b1;
            end
            else if (q_reg > rd_x_reg)
            begin
                q_reg    <= rd_x_reg;
                flag_reg <= 1'b1;
            end
            else
            begin
                flag_reg <= 1'b0;
            end
        end
        if (cmd.cap_lo)
        begin
            xi_reg <= rd_x_reg;
            yi_reg <= rd_y_reg;
        end
        if (cmd.cap_hi)
        begin
            dx_reg <= {rd_x_reg[DATA_W-1], rd_x_reg} - {xi_reg[DATA_W-1], xi_reg};
            dy_reg <= {rd_y_reg[DATA_W-1], rd_y_reg} - {yi_reg[DATA_W-1], yi_reg};
        end
        if (cmd.div_start)
        begin
            off_reg <= off_next;
        end
        if (cmd.load_out)
        begin
            value_reg   <= value_next;
            segment_reg <= h_reg;
            oor_reg     <= flag_reg;
        end
    end

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (dx_reg[DATA_W-1:0]),
        .quotient (quotient),
        .done     (div_done)
    );

    pli_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.mul_start),
        .multiplicand (grad),
        .multiplier   (off_reg),
        .product      (product),
        .done         (mul_done)
    );

    always_comb
    begin
        status.x_le_q    = (rd_x_reg <= q_reg);
        status.h_lt_lm1  = (h_reg < lm1);
        status.h1_lt_lm1 = ({1'b0, h_reg} + 1'b1) < {1'b0, lm1};
        status.h_zero    = (h_reg == '0);
        status.dx_pos    = !dx_reg[DATA_W] && (dx_reg != '0);
        status.div_done  = div_done;
        status.mul_done  = mul_done;
    end

    assign value        = value_reg;
    assign segment      = segment_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

@@ rtl/core/pli_ctrl.sv @@
`default_nettype none

module pli_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pli_pkg::pli_status_t status,
    output pli_pkg::pli_cmd_t    cmd
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RDL,
        S_CLAMP,
        S_CMPH,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_SEG,
        S_SEG_HI,
        S_SEG_CAP,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL_WAIT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.rd_sel     = ADDR_H;
        case (state_reg)
            S_IDLE:
            begin
                cmd.wr_node    = accept && !kind;
                cmd.load_query = accept && kind;
                if (accept && kind)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_sel = ADDR_ZERO;
                state_next = S_RDL;
            end
            S_RDL:
            begin
                cmd.rd_sel = ADDR_LAST;
                cmd.cap_x0 = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_CMPH;
            end
            S_CMPH:
            begin
                if (status.x_le_q)
                begin
                    state_next = status.h_lt_lm1 ? S_UP_RD : S_SEG;
                end
                else if (!status.h_zero)
                begin
                    cmd.h_dec  = 1'b1;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_SEG;
                end
            end
            S_UP_RD:
            begin
                cmd.rd_sel = ADDR_H_NEXT;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (status.x_le_q)
                begin
                    cmd.h_inc  = 1'b1;
                    state_next = status.h1_lt_lm1 ? S_UP_RD : S_SEG;
                end
                else
                begin
                    state_next = S_SEG;
                end
            end
            S_DN_RD:
            begin
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (!status.x_le_q && !status.h_zero)
                begin
                    cmd.h_dec  = 1'b1;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                cmd.set_hint = 1'b1;
                state_next   = S_SEG_HI;
            end
            S_SEG_HI:
            begin
                cmd.rd_sel = ADDR_H_NEXT;
                cmd.cap_lo = 1'b1;
                state_next = S_SEG_CAP;
            end
            S_SEG_CAP:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                if (status.dx_pos)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL_WAIT;
                end
            end
            S_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/piecewise_linear_interpolator.sv @@
// A node write request is written in the cycle it is taken and gives no result.
// A query request searches from the hint, then runs the gradient divider and then the
// multiplier before out_valid; the divider and the multiplier dominate its latency.
// A segment of zero or negative width skips both units.
// One request is worked on at a time; a new request is taken while a result waits.
// Reset clears the control state, sets the node count to two and the search hint to zero.
`default_nettype none

module piecewise_linear_interpolator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              node_count_we,
    input  logic [pli_pkg::COUNT_W-1:0]       node_count,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [pli_pkg::IDX_W-1:0]         node_index,
    input  logic signed [pli_pkg::DATA_W-1:0] node_x,
    input  logic signed [pli_pkg::DATA_W-1:0] node_y,
    input  logic signed [pli_pkg::DATA_W-1:0] query_x,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [pli_pkg::DATA_W-1:0] value,
    output logic [pli_pkg::IDX_W-1:0]         segment,
    output logic                              out_of_range
);
    import pli_pkg::*;

    pli_cmd_t    cmd;
    pli_status_t status;

    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pli_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .node_count_we (node_count_we),
        .node_count    (node_count),
        .node_index    (node_index),
        .node_x        (node_x),
        .node_y        (node_y),
        .query_x       (query_x),
        .value         (value),
        .segment       (segment),
        .out_of_range  (out_of_range)
    );

endmodule

`default_nettype wire

@@ tb/tb_piecewise_linear_interpolator.sv @@
module tb_piecewise_linear_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    localparam bit KIND_WRITE = 1'b0;
    localparam bit KIND_QUERY = 1'b1;
    localparam int ITEM_TARGET = 900;
    localparam int IDLE_PERCENT = 30;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS = 10;
    localparam int X_MIN = 32'sh8000_0000;
    localparam int X_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] nx;
        logic signed [DATA_W-1:0] ny;
        logic signed [DATA_W-1:0] qx;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         seg;
        logic                     oor;
    } lookup_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     node_count_we = 1'b0;
    logic [COUNT_W-1:0]       node_count = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     kind = 1'b0;
    logic [IDX_W-1:0]         node_index = '0;
    logic signed [DATA_W-1:0] node_x = '0;
    logic signed [DATA_W-1:0] node_y = '0;
    logic signed [DATA_W-1:0] query_x = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         segment;
    logic                     out_of_range;

    piecewise_linear_interpolator dut (.*);

    // Shadow copy of the node table, the search hint and the node count.
    logic signed [DATA_W-1:0] table_x [MAX_NODES];
    logic signed [DATA_W-1:0] table_y [MAX_NODES];
    int unsigned              search_from = 0;
    int unsigned              count_reg = 2;

    // Node abscissas as written by the stimulus, used to aim queries.
    int                       plan_x [MAX_NODES];

    request_t                 pending [$];
    request_t                 offered;
    lookup_t                  lookups_due [$];
    lookup_t                  wanted;
    int unsigned              requests_taken = 0;
    int unsigned              issued = 0;
    int unsigned              mismatches = 0;
    bit                       steady = 1'b0;
    logic                     sink_hold = 1'b0;

    function automatic int unsigned active_nodes(input int unsigned count);
        if (count < 2)
            return 2;
        if (count > MAX_NODES)
            return MAX_NODES;
        return count;
    endfunction

    function automatic lookup_t interpolate(input logic signed [DATA_W-1:0] query);
        int unsigned last;
        int unsigned h;
        longint      q;
        longint      xi;
        longint      xn;
        longint      yi;
        longint      yn;
        longint      dx;
        longint      off;
        longint      grad;
        longint      v;
        lookup_t     r;
        last = active_nodes(count_reg) - 1;
        q = query;
        r.oor = 1'b0;
        if (q < table_x[0]) begin
            q = table_x[0];
            r.oor = 1'b1;
        end else if (q > table_x[last]) begin
            q = table_x[last];
            r.oor = 1'b1;
        end
        h = search_from;
        if (h > last - 1)
            h = last - 1;
        if (table_x[h] <= q) begin
            while (h + 1 <= last - 1 && table_x[h + 1] <= q)
                h++;
        end else begin
            while (h > 0 && table_x[h] > q)
                h--;
        end
        search_from = h;
        xi = table_x[h];
        xn = table_x[h + 1];
        yi = table_y[h];
        yn = table_y[h + 1];
        dx = xn - xi;
        if (dx <= 0) begin
            v = yi;
        end else begin
            grad = ((yn - yi) * 65536) / dx;
            off = q - xi;
            if (off < 0)
                off = 0;
            if (off > dx)
                off = dx;
            v = yi + ((off * grad) >>> 16);
        end
        if (v > X_MAX)
            v = X_MAX;
        if (v < X_MIN)
            v = X_MIN;
        r.value = v[DATA_W-1:0];
        r.seg = IDX_W'(h);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                requests_taken++;
                if (offered.kind == KIND_QUERY) begin
                    lookups_due.push_back(interpolate(offered.qx));
                end else begin
                    table_x[offered.idx] = offered.nx;
                    table_y[offered.idx] = offered.ny;
                end
            end
            if (!in_valid || in_ready) begin
                if (pending.size() > 0
                        && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                    offered = pending.pop_front();
                    in_valid <= 1'b1;
                    kind <= offered.kind;
                    node_index <= offered.idx;
                    node_x <= offered.nx;
                    node_y <= offered.ny;
                    query_x <= offered.qx;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (lookups_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result value=%0d segment=%0d oor=%0b",
                                            value, segment, out_of_range));
                end else begin
                    wanted = lookups_due.pop_front();
                    if (value !== wanted.value || segment !== wanted.seg
                            || out_of_range !== wanted.oor)
                        flag_mismatch($sformatf(
                            "expected value=%0d segment=%0d oor=%0b, got %0d %0d %0b",
                            wanted.value, wanted.seg, wanted.oor,
                            value, segment, out_of_range));
                end
            end
            out_ready <= !sink_hold && (steady || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial begin
        forever #5 clk = ~clk;
    end

    // The receiver holds off for a long stretch while queries keep coming.
    initial begin
        wait (requests_taken >= HOLD_AT);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic wait_idle();
        while (pending.size() != 0 || in_valid || lookups_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input int unsigned count);
        wait_idle();
        node_count_we <= 1'b1;
        node_count <= COUNT_W'(count);
        count_reg = count & 7'h7F;
        @(posedge clk);
        node_count_we <= 1'b0;
    endtask

    task automatic put_node(input int idx, input int x, input int y);
        request_t r;
        r.kind = KIND_WRITE;
        r.idx = IDX_W'(idx);
        r.nx = x;
        r.ny = y;
        r.qx = $urandom;
        plan_x[idx] = x;
        pending.push_back(r);
        issued++;
    endtask

    task automatic put_query(input int q);
        request_t r;
        r.kind = KIND_QUERY;
        r.idx = IDX_W'($urandom);
        r.nx = $urandom;
        r.ny = $urandom;
        r.qx = q;
        pending.push_back(r);
        issued++;
    endtask

    task automatic load_table(input int n, input bit narrow);
        int xs [MAX_NODES];
        int base_x;
        int base_y;
        int i;
        int j;
        int v;
        base_x = int'($urandom) >>> 1;
        base_y = int'($urandom) >>> 1;
        for (i = 0; i < n; i++) begin
            v = narrow ? base_x + int'($urandom_range(0, 524288)) : int'($urandom);
            j = i;
            while (j > 0 && xs[j - 1] > v) begin
                xs[j] = xs[j - 1];
                j--;
            end
            xs[j] = v;
        end
        for (i = 0; i < n; i++)
            put_node(i, xs[i],
                     narrow ? base_y + int'($urandom_range(0, 1048576)) - 524288
                            : int'($urandom));
    endtask

    function automatic int pick_query(input int n);
        int     sel;
        int     k;
        longint lo;
        longint hi;
        sel = $urandom_range(99);
        k = $urandom_range(n - 2);
        if (sel < 10)
            return $urandom;
        if (sel < 20)
            return plan_x[0] - int'($urandom_range(0, 3));
        if (sel < 30)
            return plan_x[n - 1] + int'($urandom_range(0, 3));
        if (sel < 50)
            return plan_x[k] + int'($urandom_range(0, 2)) - 1;
        lo = plan_x[k];
        hi = plan_x[k + 1];
        if (hi <= lo)
            return plan_x[k];
        return int'(lo + longint'($urandom) % (hi - lo + 1));
    endfunction

    initial begin
        int unsigned phase;
        int unsigned count;
        int          n;
        int          items;
        int          sel;
        int          k;
        int unsigned fixed_counts [7];
        fixed_counts = '{0, 1, 64, 127, 3, 2, 5};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bounds at the extremes of the number range, with exact node hits.
        set_count(3);
        put_node(0, X_MIN, X_MAX);
        put_node(1, 0, X_MIN);
        put_node(2, X_MAX, X_MAX);
        put_query(X_MIN);
        put_query(X_MIN + 1);
        put_query(0);
        put_query(1);
        put_query(X_MAX);

        // Clamping below and above, and queries on the end nodes.
        set_count(2);
        put_node(0, -65536, 0);
        put_node(1, 65536, 655360);
        put_query(X_MIN);
        put_query(X_MAX);
        put_query(-65536);
        put_query(65536);
        put_query(0);

        // Zero-width and reversed segments.
        put_node(1, -65536, 131072);
        put_query(0);
        put_node(1, -131072, 131072);
        put_query(-65536);

        // Steepest gradients, rising and falling.
        put_node(0, 0, X_MIN);
        put_node(1, 1, X_MAX);
        put_query(0);
        put_query(1);
        put_node(0, 0, X_MAX);
        put_node(1, 1, X_MIN);
        put_query(1);

        phase = 0;
        while (issued < ITEM_TARGET) begin
            if (phase < 7)
                count = fixed_counts[phase];
            else if ($urandom_range(9) == 0)
                count = $urandom_range(127);
            else
                count = $urandom_range(2, 12);
            set_count(count);
            steady = (phase == 4);
            n = active_nodes(count);
            load_table(n, $urandom_range(1));
            items = $urandom_range(40, 80);
            repeat (items) begin
                sel = $urandom_range(99);
                k = $urandom_range(n - 2);
                if (sel < 6)
                    put_node($urandom_range(MAX_NODES - 1), $urandom, $urandom);
                else if (sel < 10)
                    put_node(k + 1, plan_x[k], $urandom);
                else
                    put_query(pick_query(n));
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
